[src/wsg_pkg.sv]
// Shared types and constants for the waypoint setpoint glide block.
package wsg_pkg;

    localparam int LAT_W       = 28;
    localparam int LON_W       = 29;
    localparam int DLAT_W      = LAT_W + 1;
    localparam int DLON_W      = LON_W + 1;
    localparam int MAG_W       = LON_W;
    localparam int REM_W       = MAG_W + 1;
    localparam int MODE_W      = 3;
    localparam int RUN_W       = 2;
    localparam int SPEED_W     = 24;
    localparam int STEP_W      = 16;
    localparam int WIN_W       = 16;
    localparam int INC_W       = 23;
    localparam int INC_MAG_W   = INC_W - 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 48;

    localparam logic [RUN_W-1:0] RUN_ACTIVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_CODE   = 3'd5;

    localparam logic [WIN_W-1:0]   RST_NEAR_WINDOW = 16'd160;
    localparam logic [SPEED_W-1:0] RST_MIN_SPEED   = 24'd838861;
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED   = 24'd3355443;
    localparam logic [STEP_W-1:0]  RST_DECEL_STEP  = 16'd2517;
    localparam logic [STEP_W-1:0]  RST_ACCEL_STEP  = 16'd1678;
    localparam logic [MODE_W-1:0]  RST_MODE_CODE   = 3'd3;

    localparam logic [SPEED_W-1:0]   SPEED_MAX = {SPEED_W{1'b1}};
    localparam logic [INC_MAG_W-1:0] INC_MAX   = {INC_MAG_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_STORE,
        ST_RAMP,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } seq_ctrl_t;

endpackage

[src/wsg_div.sv]
// Bit-serial restoring divider giving the Q1.FRAC_BITS ratio of short to long distance.
module wsg_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  wsg_pkg::seq_ctrl_t           ctrl,
    input  logic [wsg_pkg::MAG_W-1:0]    divisor,
    input  logic [wsg_pkg::MAG_W-1:0]    dividend,
    output logic [FRAC_BITS:0]           quotient
);

    logic [wsg_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [wsg_pkg::MAG_W-1:0] div_reg, div_next;
    logic [FRAC_BITS:0]        q_reg, q_next;
    logic [wsg_pkg::REM_W-1:0] diff;
    logic                      ge;

    always_comb begin
        ge       = rem_reg >= {1'b0, div_reg};
        diff     = rem_reg - {1'b0, div_reg};
        rem_next = rem_reg;
        div_next = div_reg;
        q_next   = q_reg;
        if (ctrl.load) begin
            rem_next = {1'b0, dividend};
            div_next = divisor;
            q_next   = '0;
        end else if (ctrl.step) begin
            rem_next = ge ? {diff[wsg_pkg::MAG_W-1:0], 1'b0}
                          : {rem_reg[wsg_pkg::MAG_W-1:0], 1'b0};
            q_next   = {q_reg[FRAC_BITS-1:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;

endmodule

[src/wsg_mul.sv]
// Bit-serial shift-add multiplier forming a saturated increment magnitude from speed and ratio.
module wsg_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  wsg_pkg::seq_ctrl_t              ctrl,
    input  logic [wsg_pkg::SPEED_W-1:0]     speed,
    input  logic [FRAC_BITS:0]              ratio,
    output logic [wsg_pkg::INC_MAG_W-1:0]   magnitude
);

    logic [wsg_pkg::SPEED_W-1:0] acc_reg, acc_next;
    logic [FRAC_BITS:0]          rsh_reg, rsh_next;
    logic                        lsb_reg, lsb_next;
    logic [wsg_pkg::SPEED_W:0]   sum;
    logic [wsg_pkg::SPEED_W:0]   prod;

    always_comb begin
        sum      = {1'b0, acc_reg} + (rsh_reg[0] ? {1'b0, speed} : '0);
        acc_next = acc_reg;
        rsh_next = rsh_reg;
        lsb_next = lsb_reg;
        if (ctrl.load) begin
            acc_next = '0;
            rsh_next = ratio;
            lsb_next = 1'b0;
        end else if (ctrl.step) begin
            acc_next = sum[wsg_pkg::SPEED_W:1];
            lsb_next = sum[0];
            rsh_next = {1'b0, rsh_reg[FRAC_BITS:1]};
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rsh_reg <= rsh_next;
        lsb_reg <= lsb_next;
    end

    // The product shifted down by FRAC_BITS is the accumulator with the last bit shifted out.
    always_comb begin
        prod = {acc_reg, lsb_reg};
        if (|prod[wsg_pkg::SPEED_W:wsg_pkg::INC_MAG_W]) begin
            magnitude = wsg_pkg::INC_MAX;
        end else begin
            magnitude = prod[wsg_pkg::INC_MAG_W-1:0];
        end
    end

endmodule

[src/waypoint_setpoint_glide.sv]
// Top level of the waypoint setpoint glide block: control sequencer, state and stream ports.
// An inactive leg goes from LOAD straight to DONE; the flying phase runs LOAD, RAMP, MUL
// and DONE; a phase-0 tick runs LOAD, PREP, DIV and STORE, then RAMP and MUL if it flies,
// and then DONE; the ratio divider and the increment multiplier work bit by bit. One beat
// is taken at a time, the next one the cycle after the result is registered. Reset clears
// the leg state and restores the registers.
module waypoint_setpoint_glide #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // target_lat, target_lon, setpoint_lat, setpoint_lon, mode_now, run_state, begin_leg
    input  logic [wsg_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // lat_increment, lon_increment, flying_leg, leg_active
    output logic [wsg_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wsg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(FRAC_BITS);
    localparam logic [FRAC_BITS:0] ONE      = {1'b1, {FRAC_BITS{1'b0}}};

    wsg_pkg::state_t state_reg, state_next;

    logic [wsg_pkg::WIN_W-1:0]   near_window_reg;
    logic [wsg_pkg::SPEED_W-1:0] min_speed_reg;
    logic [wsg_pkg::SPEED_W-1:0] max_speed_reg;
    logic [wsg_pkg::STEP_W-1:0]  decel_step_reg;
    logic [wsg_pkg::STEP_W-1:0]  accel_step_reg;
    logic [wsg_pkg::MODE_W-1:0]  mode_code_reg;

    logic                        active_reg, active_next;
    logic                        phase_reg, phase_next;
    logic [wsg_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic [FRAC_BITS:0]          lat_ratio_reg, lat_ratio_next;
    logic [FRAC_BITS:0]          lon_ratio_reg, lon_ratio_next;
    logic                        flying_reg, flying_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    logic [wsg_pkg::DLAT_W-1:0]  dlat_reg, dlat_next;
    logic [wsg_pkg::DLON_W-1:0]  dlon_reg, dlon_next;
    logic [wsg_pkg::LAT_W-1:0]   alat_reg, alat_next;
    logic [wsg_pkg::MAG_W-1:0]   alon_reg, alon_next;
    logic                        lat_neg_reg, lat_neg_next;
    logic                        lon_neg_reg, lon_neg_next;
    logic                        lat_zero_reg, lat_zero_next;
    logic                        lon_zero_reg, lon_zero_next;
    logic                        lat_long_reg, lat_long_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [wsg_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    wsg_pkg::seq_ctrl_t          div_ctrl, mul_ctrl;
    logic [wsg_pkg::MAG_W-1:0]   div_long, div_short;
    logic [FRAC_BITS:0]          quotient;
    logic [wsg_pkg::INC_MAG_W-1:0] lat_mag, lon_mag;

    logic [wsg_pkg::LAT_W-1:0]   in_tlat, in_slat;
    logic [wsg_pkg::LON_W-1:0]   in_tlon, in_slon;
    logic [wsg_pkg::MODE_W-1:0]  in_mode;
    logic [wsg_pkg::RUN_W-1:0]   in_run;
    logic                        in_begin;

    logic                        lat_ge;
    logic [wsg_pkg::DLAT_W-1:0]  dlat_abs;
    logic [wsg_pkg::DLON_W-1:0]  dlon_abs;
    logic                        near;
    logic [wsg_pkg::SPEED_W:0]   speed_up;
    logic [wsg_pkg::INC_W-1:0]   lat_inc, lon_inc;
    logic                        out_free;

    assign in_tlat  = s_tdata[27:0];
    assign in_tlon  = s_tdata[56:28];
    assign in_slat  = s_tdata[84:57];
    assign in_slon  = s_tdata[113:85];
    assign in_mode  = s_tdata[116:114];
    assign in_run   = s_tdata[118:117];
    assign in_begin = s_tdata[119];

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign lat_ge    = {1'b0, alat_reg} >= alon_reg;
    assign div_long  = lat_ge ? {1'b0, alat_reg} : alon_reg;
    assign div_short = lat_ge ? alon_reg : {1'b0, alat_reg};

    wsg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .divisor  (div_long),
        .dividend (div_short),
        .quotient (quotient)
    );

    wsg_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_lat (
        .aclk      (aclk),
        .ctrl      (mul_ctrl),
        .speed     (speed_reg),
        .ratio     (lat_ratio_reg),
        .magnitude (lat_mag)
    );

    wsg_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_lon (
        .aclk      (aclk),
        .ctrl      (mul_ctrl),
        .speed     (speed_reg),
        .ratio     (lon_ratio_reg),
        .magnitude (lon_mag)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wsg_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = wsg_pkg::ST_LOAD;
                end
            end
            wsg_pkg::ST_LOAD: begin
                priority if (!active_reg) begin
                    state_next = wsg_pkg::ST_DONE;
                end else if (!phase_reg) begin
                    state_next = wsg_pkg::ST_PREP;
                end else begin
                    state_next = wsg_pkg::ST_RAMP;
                end
            end
            wsg_pkg::ST_PREP: begin
                state_next = wsg_pkg::ST_DIV;
            end
            wsg_pkg::ST_DIV: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = wsg_pkg::ST_STORE;
                end
            end
            wsg_pkg::ST_STORE: begin
                state_next = phase_reg ? wsg_pkg::ST_RAMP : wsg_pkg::ST_DONE;
            end
            wsg_pkg::ST_RAMP: begin
                state_next = wsg_pkg::ST_MUL;
            end
            wsg_pkg::ST_MUL: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = wsg_pkg::ST_DONE;
                end
            end
            wsg_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = wsg_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        s_tready = (state_reg == wsg_pkg::ST_IDLE);
        div_ctrl = '{load: state_reg == wsg_pkg::ST_PREP, step: state_reg == wsg_pkg::ST_DIV};
        mul_ctrl = '{load: state_reg == wsg_pkg::ST_RAMP, step: state_reg == wsg_pkg::ST_MUL};
    end

    always_comb begin
        dlat_abs = dlat_reg[wsg_pkg::DLAT_W-1] ? (wsg_pkg::DLAT_W'(0) - dlat_reg) : dlat_reg;
        dlon_abs = dlon_reg[wsg_pkg::DLON_W-1] ? (wsg_pkg::DLON_W'(0) - dlon_reg) : dlon_reg;
        near     = (alat_reg < wsg_pkg::LAT_W'(near_window_reg))
                && (alon_reg < wsg_pkg::MAG_W'(near_window_reg));
        speed_up = {1'b0, speed_reg} + (wsg_pkg::SPEED_W + 1)'(accel_step_reg);
        lat_inc  = '0;
        lon_inc  = '0;
        if (flying_reg && !lat_zero_reg) begin
            lat_inc = lat_neg_reg ? (wsg_pkg::INC_W'(0) - {1'b0, lat_mag}) : {1'b0, lat_mag};
        end
        if (flying_reg && !lon_zero_reg) begin
            lon_inc = lon_neg_reg ? (wsg_pkg::INC_W'(0) - {1'b0, lon_mag}) : {1'b0, lon_mag};
        end
    end

    always_comb begin
        active_next    = active_reg;
        phase_next     = phase_reg;
        speed_next     = speed_reg;
        lat_ratio_next = lat_ratio_reg;
        lon_ratio_next = lon_ratio_reg;
        flying_next    = flying_reg;
        cnt_next       = cnt_reg;
        dlat_next      = dlat_reg;
        dlon_next      = dlon_reg;
        alat_next      = alat_reg;
        alon_next      = alon_reg;
        lat_neg_next   = lat_neg_reg;
        lon_neg_next   = lon_neg_reg;
        lat_zero_next  = lat_zero_reg;
        lon_zero_next  = lon_zero_reg;
        lat_long_next  = lat_long_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            wsg_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    dlat_next   = {in_tlat[wsg_pkg::LAT_W-1], in_tlat}
                                - {in_slat[wsg_pkg::LAT_W-1], in_slat};
                    dlon_next   = {in_tlon[wsg_pkg::LON_W-1], in_tlon}
                                - {in_slon[wsg_pkg::LON_W-1], in_slon};
                    flying_next = 1'b0;
                    if (in_begin) begin
                        active_next = 1'b1;
                        phase_next  = 1'b0;
                    end
                    if (in_mode != mode_code_reg && in_run == wsg_pkg::RUN_ACTIVE) begin
                        active_next = 1'b0;
                    end
                end
            end
            wsg_pkg::ST_LOAD: begin
                alat_next     = dlat_abs[wsg_pkg::LAT_W-1:0];
                alon_next     = dlon_abs[wsg_pkg::MAG_W-1:0];
                lat_neg_next  = dlat_reg[wsg_pkg::DLAT_W-1];
                lon_neg_next  = dlon_reg[wsg_pkg::DLON_W-1];
                lat_zero_next = (dlat_reg == '0);
                lon_zero_next = (dlon_reg == '0);
            end
            wsg_pkg::ST_PREP: begin
                speed_next    = '0;
                lat_long_next = lat_ge;
                cnt_next      = '0;
                if (lat_ratio_reg == ONE || lon_ratio_reg == ONE) begin
                    phase_next = 1'b1;
                end
            end
            wsg_pkg::ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
            end
            wsg_pkg::ST_STORE: begin
                if (lat_long_reg) begin
                    lat_ratio_next = ONE;
                    lon_ratio_next = lat_zero_reg ? '0 : quotient;
                end else begin
                    lat_ratio_next = quotient;
                    lon_ratio_next = ONE;
                end
            end
            wsg_pkg::ST_RAMP: begin
                flying_next = 1'b1;
                cnt_next    = '0;
                if (lat_zero_reg && lon_zero_reg) begin
                    active_next = 1'b0;
                end
                priority if (near && speed_reg > min_speed_reg) begin
                    speed_next = (speed_reg > wsg_pkg::SPEED_W'(decel_step_reg))
                               ? speed_reg - wsg_pkg::SPEED_W'(decel_step_reg) : '0;
                end else if (speed_reg < max_speed_reg) begin
                    speed_next = speed_up[wsg_pkg::SPEED_W]
                               ? wsg_pkg::SPEED_MAX : speed_up[wsg_pkg::SPEED_W-1:0];
                end
            end
            wsg_pkg::ST_MUL: begin
                cnt_next = cnt_reg + 1'b1;
            end
            wsg_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {active_reg, flying_reg, lon_inc, lat_inc};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= wsg_pkg::ST_IDLE;
            near_window_reg <= wsg_pkg::RST_NEAR_WINDOW;
            min_speed_reg   <= wsg_pkg::RST_MIN_SPEED;
            max_speed_reg   <= wsg_pkg::RST_MAX_SPEED;
            decel_step_reg  <= wsg_pkg::RST_DECEL_STEP;
            accel_step_reg  <= wsg_pkg::RST_ACCEL_STEP;
            mode_code_reg   <= wsg_pkg::RST_MODE_CODE;
            active_reg      <= 1'b0;
            phase_reg       <= 1'b0;
            speed_reg       <= '0;
            lat_ratio_reg   <= '0;
            lon_ratio_reg   <= '0;
            flying_reg      <= 1'b0;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            speed_reg     <= speed_next;
            lat_ratio_reg <= lat_ratio_next;
            lon_ratio_reg <= lon_ratio_next;
            flying_reg    <= flying_next;
            cnt_reg       <= cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    wsg_pkg::CFG_NEAR_WINDOW: near_window_reg <= cfg_data[wsg_pkg::WIN_W-1:0];
                    wsg_pkg::CFG_MIN_SPEED:   min_speed_reg   <= cfg_data;
                    wsg_pkg::CFG_MAX_SPEED:   max_speed_reg   <= cfg_data;
                    wsg_pkg::CFG_DECEL_STEP:  decel_step_reg  <= cfg_data[wsg_pkg::STEP_W-1:0];
                    wsg_pkg::CFG_ACCEL_STEP:  accel_step_reg  <= cfg_data[wsg_pkg::STEP_W-1:0];
                    wsg_pkg::CFG_MODE_CODE:   mode_code_reg   <= cfg_data[wsg_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        dlat_reg     <= dlat_next;
        dlon_reg     <= dlon_next;
        alat_reg     <= alat_next;
        alon_reg     <= alon_next;
        lat_neg_reg  <= lat_neg_next;
        lon_neg_reg  <= lon_neg_next;
        lat_zero_reg <= lat_zero_next;
        lon_zero_reg <= lon_zero_next;
        lat_long_reg <= lat_long_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // After the ratios are stored, one of them is always exactly one.
    a_ratio_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wsg_pkg::ST_STORE) |=> (lat_ratio_reg == ONE || lon_ratio_reg == ONE))
        else $error("neither ratio is one after the ratio update");

    // The serial counter never runs past the last bit.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wsg_pkg::ST_DIV || state_reg == wsg_pkg::ST_MUL) |-> (cnt_reg <= CNT_LAST))
        else $error("serial bit counter out of range");

    // A beat that did not fly carries zero increments.
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tdata_reg[46]) |-> (m_tdata_reg[45:0] == '0))
        else $error("non-zero increment on a beat that did not fly");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the waypoint setpoint glide block: scoreboard class and stimulus.
import wsg_pkg::*;

typedef struct {
    logic signed [LAT_W-1:0] tgt_lat;
    logic signed [LON_W-1:0] tgt_lon;
    logic signed [LAT_W-1:0] sp_lat;
    logic signed [LON_W-1:0] sp_lon;
    logic [MODE_W-1:0]       mode;
    logic [RUN_W-1:0]        run;
    logic                    begin_leg;
} nav_tick_t;

typedef struct packed {
    logic               active;
    logic               flying;
    logic [INC_W-1:0]   lon_inc;
    logic [INC_W-1:0]   lat_inc;
} glide_out_t;

class glide_scoreboard #(int FRAC = 16);
    localparam int RATIO_W = FRAC + 1;

    logic [WIN_W-1:0]   near_window;
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] max_speed;
    logic [STEP_W-1:0]  decel_step;
    logic [STEP_W-1:0]  accel_step;
    logic [MODE_W-1:0]  wp_mode;

    bit                 leg_on;
    bit                 flying_phase;
    bit [SPEED_W-1:0]   speed;
    bit [RATIO_W-1:0]   lat_ratio;
    bit [RATIO_W-1:0]   lon_ratio;

    glide_out_t         due[$];
    int                 mismatches;
    int                 results;
    int                 flown;
    int                 reached;
    int                 aborted;

    function new();
        near_window  = RST_NEAR_WINDOW;
        min_speed    = RST_MIN_SPEED;
        max_speed    = RST_MAX_SPEED;
        decel_step   = RST_DECEL_STEP;
        accel_step   = RST_ACCEL_STEP;
        wp_mode      = RST_MODE_CODE;
        leg_on       = 1'b0;
        flying_phase = 1'b0;
        speed        = '0;
        lat_ratio    = '0;
        lon_ratio    = '0;
        mismatches   = 0;
        results      = 0;
        flown        = 0;
        reached      = 0;
        aborted      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_NEAR_WINDOW: near_window = val[WIN_W-1:0];
            CFG_MIN_SPEED:   min_speed   = val[SPEED_W-1:0];
            CFG_MAX_SPEED:   max_speed   = val[SPEED_W-1:0];
            CFG_DECEL_STEP:  decel_step  = val[STEP_W-1:0];
            CFG_ACCEL_STEP:  accel_step  = val[STEP_W-1:0];
            CFG_MODE_CODE:   wp_mode     = val[MODE_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [INC_W-1:0] axis_step(longint d, bit [RATIO_W-1:0] ratio);
        longint unsigned  m;
        logic [INC_W-1:0] v;
        m = (longint'(speed) * longint'(ratio)) >> FRAC;
        if (m > INC_MAX) m = INC_MAX;
        v = INC_W'(m);
        if (d < 0) v = -v;
        else if (d == 0) v = '0;
        return v;
    endfunction

    function void note_tick(nav_tick_t t);
        longint          dlat;
        longint          dlon;
        longint unsigned alat;
        longint unsigned alon;
        longint unsigned one;
        longint unsigned s;
        glide_out_t      r;
        one  = 64'd1 << FRAC;
        dlat = longint'(t.tgt_lat) - longint'(t.sp_lat);
        dlon = longint'(t.tgt_lon) - longint'(t.sp_lon);
        alat = (dlat < 0) ? -dlat : dlat;
        alon = (dlon < 0) ? -dlon : dlon;
        r    = '0;
        if (t.begin_leg) begin
            leg_on       = 1'b1;
            flying_phase = 1'b0;
        end
        if (t.mode != wp_mode && t.run == RUN_ACTIVE) begin
            if (leg_on) aborted++;
            leg_on = 1'b0;
        end
        if (leg_on) begin
            if (!flying_phase) begin
                speed = '0;
                if (lat_ratio == one || lon_ratio == one) flying_phase = 1'b1;
                if (alat >= alon) begin
                    lon_ratio = (alat != 0) ? RATIO_W'((alon << FRAC) / alat) : '0;
                    lat_ratio = RATIO_W'(one);
                end else begin
                    lat_ratio = RATIO_W'((alat << FRAC) / alon);
                    lon_ratio = RATIO_W'(one);
                end
            end
            if (flying_phase) begin
                r.flying = 1'b1;
                flown++;
                if (dlat == 0 && dlon == 0) begin
                    leg_on = 1'b0;
                    reached++;
                end
                if (alat < near_window && alon < near_window && speed > min_speed) begin
                    speed = (speed > decel_step) ? speed - decel_step : '0;
                end else if (speed < max_speed) begin
                    s     = speed + accel_step;
                    speed = (s > SPEED_MAX) ? SPEED_MAX : s[SPEED_W-1:0];
                end
                r.lat_inc = axis_step(dlat, lat_ratio);
                r.lon_inc = axis_step(dlon, lon_ratio);
            end
        end
        r.active = leg_on;
        due.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
        glide_out_t got;
        glide_out_t want;
        got = d;
        results++;
        if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with nothing expected: %h", results, d);
            return;
        end
        want = due.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d mismatch: expected lat %0d lon %0d flying %0b active %0b",
                         results, $signed(want.lat_inc), $signed(want.lon_inc),
                         want.flying, want.active);
                $display("result %0d mismatch: got lat %0d lon %0d flying %0b active %0b",
                         results, $signed(got.lat_inc), $signed(got.lon_inc),
                         got.flying, got.active);
            end
        end
    endfunction

    function int pending();
        return due.size();
    endfunction
endclass

module testbench;
    localparam int FRAC        = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LAT_LIM     = 90_000_000;
    localparam int LON_LIM     = 180_000_000;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {SET_RESET, SET_HIGH, SET_LOW, SET_MID, SET_RANDOM} setting_e;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    glide_scoreboard #(FRAC) glide;

    int cycles         = 0;
    int sent           = 0;
    int settings_done  = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req_cnt   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int src_pct[4]     = '{0, 48, 0, 26};
    int sink_pct[4]    = '{0, 0, 48, 26};

    waypoint_setpoint_glide #(.FRAC_BITS(FRAC)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("waypoint_setpoint_glide regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) glide.check_result(m_tdata);
            if (hold_seen != hold_req_cnt) begin
                hold_seen <= hold_req_cnt;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    function automatic longint spread(int n);
        return longint'($urandom_range(2 * n)) - n;
    endfunction

    function automatic longint pick_coord(int lim);
        if ($urandom_range(15) == 0) return ($urandom_range(1) != 0) ? lim : -lim;
        return spread(lim);
    endfunction

    function automatic longint clamp(longint v, int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic nav_tick_t mk(int tla, int tlo, int sla, int slo,
                                     logic [MODE_W-1:0] mode, logic [RUN_W-1:0] run,
                                     logic beg);
        nav_tick_t t;
        t.tgt_lat   = LAT_W'(tla);
        t.tgt_lon   = LON_W'(tlo);
        t.sp_lat    = LAT_W'(sla);
        t.sp_lon    = LON_W'(slo);
        t.mode      = mode;
        t.run       = run;
        t.begin_leg = beg;
        return t;
    endfunction

    task automatic push_tick(input nav_tick_t t);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.begin_leg, t.run, t.mode, t.sp_lon, t.sp_lat, t.tgt_lon, t.tgt_lat};
        do @(posedge aclk); while (!s_tready);
        glide.note_tick(t);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (glide.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        glide.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input setting_e s);
        logic [CFG_DATA_W-1:0] nw, mn, mx, dc, ac, md;
        case (s)
            SET_RESET: begin
                nw = CFG_DATA_W'(RST_NEAR_WINDOW);
                mn = CFG_DATA_W'(RST_MIN_SPEED);
                mx = CFG_DATA_W'(RST_MAX_SPEED);
                dc = CFG_DATA_W'(RST_DECEL_STEP);
                ac = CFG_DATA_W'(RST_ACCEL_STEP);
                md = CFG_DATA_W'(RST_MODE_CODE);
            end
            SET_HIGH: begin
                nw = CFG_DATA_W'({WIN_W{1'b1}});
                mn = '0;
                mx = CFG_DATA_W'(SPEED_MAX);
                dc = CFG_DATA_W'({STEP_W{1'b1}});
                ac = CFG_DATA_W'({STEP_W{1'b1}});
                md = CFG_DATA_W'({MODE_W{1'b1}});
            end
            SET_LOW: begin
                nw = '0;
                mn = '0;
                mx = '0;
                dc = '0;
                ac = '0;
                md = '0;
            end
            SET_MID: begin
                nw = CFG_DATA_W'(5000);
                mn = CFG_DATA_W'(200000);
                mx = CFG_DATA_W'(SPEED_MAX);
                dc = CFG_DATA_W'(40000);
                ac = CFG_DATA_W'(30000);
                md = CFG_DATA_W'(RST_MODE_CODE);
            end
            default: begin
                nw = CFG_DATA_W'($urandom_range(4000));
                mn = CFG_DATA_W'($urandom_range(1 << 20));
                mx = CFG_DATA_W'($urandom_range(SPEED_MAX));
                dc = CFG_DATA_W'($urandom_range(65535));
                ac = CFG_DATA_W'($urandom_range(65535, 1000));
                md = CFG_DATA_W'($urandom_range(7));
            end
        endcase
        write_reg(CFG_NEAR_WINDOW, nw);
        write_reg(CFG_MIN_SPEED, mn);
        write_reg(CFG_MAX_SPEED, mx);
        write_reg(CFG_DECEL_STEP, dc);
        write_reg(CFG_ACCEL_STEP, ac);
        write_reg(CFG_MODE_CODE, md);
        settings_done++;
    endtask

    task automatic noise_tick();
        nav_tick_t t;
        t.tgt_lat   = LAT_W'(pick_coord(LAT_LIM));
        t.tgt_lon   = LON_W'(pick_coord(LON_LIM));
        t.sp_lat    = LAT_W'(pick_coord(LAT_LIM));
        t.sp_lon    = LON_W'(pick_coord(LON_LIM));
        t.mode      = MODE_W'($urandom_range(7));
        t.run       = RUN_W'($urandom_range(2));
        t.begin_leg = 1'($urandom_range(1));
        push_tick(t);
    endtask

    task automatic fly_leg(input bit long_leg);
        nav_tick_t t;
        longint    off_lat;
        longint    off_lon;
        int        ticks;
        t.tgt_lat = LAT_W'(pick_coord(LAT_LIM));
        t.tgt_lon = LON_W'(pick_coord(LON_LIM));
        case ($urandom_range(3))
            0: begin
                off_lat = spread(300);
                off_lon = spread(300);
            end
            1: begin
                off_lat = spread(70000);
                off_lon = spread(70000);
            end
            2: begin
                off_lat = spread(20_000_000);
                off_lon = spread(20_000_000);
            end
            default: begin
                off_lat = pick_coord(LAT_LIM) - longint'(t.tgt_lat);
                off_lon = pick_coord(LON_LIM) - longint'(t.tgt_lon);
            end
        endcase
        case ($urandom_range(7))
            0: off_lat = 0;
            1: off_lon = 0;
            2: off_lon = ($urandom_range(1) != 0) ? off_lat : -off_lat;
            default: ;
        endcase
        ticks = long_leg ? $urandom_range(280, 150) : $urandom_range(30, 2);
        for (int i = 0; i < ticks; i++) begin
            t.sp_lat    = LAT_W'(clamp(longint'(t.tgt_lat) + off_lat, LAT_LIM));
            t.sp_lon    = LON_W'(clamp(longint'(t.tgt_lon) + off_lon, LON_LIM));
            t.mode      = ($urandom_range(39) == 0) ? MODE_W'($urandom_range(7)) : glide.wp_mode;
            t.run       = ($urandom_range(7) == 0) ? RUN_W'($urandom_range(2)) : RUN_ACTIVE;
            t.begin_leg = (i == 0) || ($urandom_range(99) == 0);
            push_tick(t);
            if (i >= ticks - 3) begin
                off_lat = 0;
                off_lon = 0;
            end else if ($urandom_range(long_leg ? 15 : 1) == 0) begin
                off_lat = off_lat - off_lat * int'($urandom_range(4)) / 8;
                off_lon = off_lon - off_lon * int'($urandom_range(4)) / 8;
            end
        end
    endtask

    initial begin
        logic [MODE_W-1:0] wp;
        int                stop_at;
        bit                held;
        glide = new();
        wp    = RST_MODE_CODE;
        held  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Opening leg: the ratios start from zero, so the first tick only prepares.
        push_tick(mk(LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM, wp, RUN_ACTIVE, 1'b1));
        push_tick(mk(LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM, wp, RUN_ACTIVE, 1'b0));
        push_tick(mk(LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM, wp, RUN_ACTIVE, 1'b0));
        push_tick(mk(-LAT_LIM, -LON_LIM, LAT_LIM, LON_LIM, wp, RUN_ACTIVE, 1'b1));
        push_tick(mk(1000, -2000, 1000, -2000, wp, RUN_ACTIVE, 1'b1));
        push_tick(mk(5000, 7000, 0, 2000, wp, RUN_ACTIVE, 1'b1));
        push_tick(mk(5000, 7000, 0, 2000, wp, RUN_ACTIVE, 1'b0));
        push_tick(mk(-100, 50, 0, 0, wp, RUN_ACTIVE, 1'b1));
        push_tick(mk(-100, 50, 0, 0, 3'd5, RUN_ACTIVE, 1'b0));
        push_tick(mk(0, 0, 300, -300, wp, RUN_ACTIVE, 1'b1));
        push_tick(mk(0, 0, 300, -300, 3'd6, 2'd3, 1'b0));
        push_tick(mk(0, 0, 300, -300, 3'd0, 2'd0, 1'b0));
        push_tick(mk(0, 0, 300, -300, 3'd7, 2'd1, 1'b0));
        push_tick(mk(0, 0, 300, -300, 3'd5, RUN_ACTIVE, 1'b0));
        push_tick(mk(0, 0, 300, -300, 3'd4, RUN_ACTIVE, 1'b1));
        push_tick(mk(0, 1, 0, 0, wp, RUN_ACTIVE, 1'b1));
        push_tick(mk(200, 200, 200, 200, wp, RUN_ACTIVE, 1'b0));
        drain();
        apply_setting(SET_HIGH);
        wp = glide.wp_mode;
        push_tick(mk(10, -10, 0, 0, wp, RUN_ACTIVE, 1'b1));
        push_tick(mk(10, -10, 0, 0, wp, RUN_ACTIVE, 1'b0));
        push_tick(mk(10, -10, 0, 0, wp, RUN_ACTIVE, 1'b0));

        for (int blk = 0; blk < 8; blk++) begin
            drain();
            apply_setting(blk < 4 ? setting_e'(blk) : SET_RANDOM);
            src_idle_pct   =  src_pct[blk % 4];
            sink_stall_pct <= sink_pct[blk % 4];
            stop_at        =  sent + 210;
            while (sent < stop_at) begin
                if (blk == 0 && !held && sent > stop_at - 150) begin
                    hold_req_cnt <= hold_req_cnt + 1;
                    held         =  1'b1;
                end
                if ($urandom_range(3) == 0) noise_tick();
                else fly_leg(glide.accel_step >= 30000 && $urandom_range(9) == 0);
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("Sent %0d input beats and checked %0d result beats over %0d register settings.",
                 sent, glide.results, settings_done);
        $display("%0d flying ticks, %0d legs brought to target, %0d legs aborted, %0d mismatches.",
                 glide.flown, glide.reached, glide.aborted, glide.mismatches);
        if (glide.mismatches == 0 && glide.pending() == 0) begin
            $display("waypoint_setpoint_glide regression: pass");
        end else begin
            $display("waypoint_setpoint_glide regression: fail");
        end
        $finish;
    end
endmodule

[files.f]
src/wsg_pkg.sv
src/wsg_div.sv
src/wsg_mul.sv
src/waypoint_setpoint_glide.sv
tb/sv/testbench.sv
